[rtl/core/ptrc_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, codes and types of the per-target reason counter table.
package ptrc_pkg;

    localparam int TARGETS            = 16;
    localparam int ENTRIES_PER_TARGET = 8;

    localparam int MODE_W   = 2;
    localparam int TGT_W    = 4;
    localparam int REASON_W = 16;
    localparam int COUNT_W  = 16;
    localparam int SLOT_W   = 3;

    localparam int IDX_W  = $clog2(ENTRIES_PER_TARGET + 1);
    localparam int ADDR_W = $clog2(TARGETS * ENTRIES_PER_TARGET);
    localparam int DEPTH  = TARGETS * ENTRIES_PER_TARGET;

    localparam logic [MODE_W-1:0] MODE_UPDATE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WB_DONE = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [REASON_W-1:0] reason;
        logic [COUNT_W-1:0]  count;
    } t_entry;

endpackage

[rtl/core/per_target_reason_count_table.sv]
`timescale 1ns / 1ps
// Per-target reason counter table: sequencer, shared compare unit, entry memory, output register.
// Steps: clear, writeback done or an unused mode go to S_DONE; an update passes S_CHECK (a
//   rejected one to S_DONE), then S_READ, S_CMP per used entry up to a hit, else S_APPEND.
// Throughput: one item at a time, the next accepted in the cycle after its result is loaded; the
//   entry memory is read once per compare step, and a result may wait in the output register.
// Reset: synchronous; clears used counts, dirty flags and handshake state, not entry memory.
module per_target_reason_count_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [ptrc_pkg::MODE_W-1:0]   i_mode,
    input  logic [ptrc_pkg::TGT_W-1:0]    i_target,
    input  logic [ptrc_pkg::REASON_W-1:0] i_reason,
    input  logic                          i_request_writeback,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_status,
    output logic [ptrc_pkg::COUNT_W-1:0]  o_count_after,
    output logic [ptrc_pkg::SLOT_W-1:0]   o_slot,
    output logic                          o_restart_save
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_CMP,
        S_APPEND,
        S_DONE
    } t_state;

    t_state                          r_state;
    logic [ptrc_pkg::TGT_W-1:0]      r_target;
    logic [ptrc_pkg::REASON_W-1:0]   r_reason;
    logic                            r_wb;
    logic [ptrc_pkg::IDX_W-1:0]      r_idx;
    logic [ptrc_pkg::IDX_W-1:0]      r_used_cnt;
    logic [ptrc_pkg::IDX_W-1:0]      r_used [ptrc_pkg::TARGETS];
    logic [ptrc_pkg::TARGETS-1:0]    r_dirty;

    logic                            r_res_status;
    logic [ptrc_pkg::COUNT_W-1:0]    r_res_count;
    logic [ptrc_pkg::SLOT_W-1:0]     r_res_slot;
    logic                            r_res_restart;

    ptrc_pkg::t_entry                r_mem [ptrc_pkg::DEPTH];
    ptrc_pkg::t_entry                r_rd_data;

    logic                            w_accept;
    logic                            w_in_tgt_ok;
    logic                            w_tgt_ok;
    logic [ptrc_pkg::ADDR_W-1:0]     w_addr;
    logic                            w_hit;
    logic                            w_mem_we;
    logic [ptrc_pkg::COUNT_W-1:0]    w_new_count;
    ptrc_pkg::t_entry                w_wdata;
    logic                            w_out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_in_tgt_ok = (int'(i_target) < ptrc_pkg::TARGETS);
    assign w_tgt_ok    = (int'(r_target) < ptrc_pkg::TARGETS);
    assign w_out_free  = !o_out_valid || !i_out_stall;

    assign w_addr = ptrc_pkg::ADDR_W'(int'(r_target) * ptrc_pkg::ENTRIES_PER_TARGET
                                      + int'(r_idx));

    // shared compare unit
    assign w_hit = (r_rd_data.reason == r_reason);

    always_comb begin
        if (r_state == S_CMP) begin
            w_new_count = (r_rd_data.count == ptrc_pkg::COUNT_MAX) ?
                          r_rd_data.count : r_rd_data.count + ptrc_pkg::COUNT_W'(1);
        end else begin
            w_new_count = ptrc_pkg::COUNT_W'(1);
        end
    end

    assign w_mem_we       = ((r_state == S_CMP) && w_hit) || (r_state == S_APPEND);
    assign w_wdata.reason = r_reason;
    assign w_wdata.count  = w_new_count;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_addr] <= w_wdata;
        end
        r_rd_data <= r_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dirty     <= '0;
            o_out_valid <= 1'b0;
            for (int t = 0; t < ptrc_pkg::TARGETS; t++) begin
                r_used[t] <= '0;
            end
        end else begin
            if (o_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_target      <= i_target;
                        r_reason      <= i_reason;
                        r_wb          <= i_request_writeback;
                        r_idx         <= '0;
                        r_res_status  <= ptrc_pkg::STATUS_OK;
                        r_res_count   <= '0;
                        r_res_slot    <= '0;
                        r_res_restart <= 1'b0;
                        case (i_mode)
                            ptrc_pkg::MODE_UPDATE: begin
                                r_state <= S_CHECK;
                            end
                            ptrc_pkg::MODE_CLEAR: begin
                                r_dirty <= '0;
                                for (int t = 0; t < ptrc_pkg::TARGETS; t++) begin
                                    r_used[t] <= '0;
                                end
                                r_state <= S_DONE;
                            end
                            ptrc_pkg::MODE_WB_DONE: begin
                                if (w_in_tgt_ok) begin
                                    r_dirty[i_target] <= 1'b0;
                                end
                                r_state <= S_DONE;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_CHECK: begin
                    if (!w_tgt_ok ||
                        r_used[r_target] >= ptrc_pkg::IDX_W'(ptrc_pkg::ENTRIES_PER_TARGET)) begin
                        r_res_status <= ptrc_pkg::STATUS_FULL;
                        r_state      <= S_DONE;
                    end else begin
                        r_used_cnt <= r_used[r_target];
                        r_state    <= (r_used[r_target] == '0) ? S_APPEND : S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (w_hit) begin
                        r_res_count   <= w_new_count;
                        r_res_slot    <= ptrc_pkg::SLOT_W'(r_idx);
                        r_res_restart <= r_wb || r_dirty[r_target];
                        if (r_wb) begin
                            r_dirty[r_target] <= 1'b1;
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_idx   <= r_idx + ptrc_pkg::IDX_W'(1);
                        r_state <= (r_idx + ptrc_pkg::IDX_W'(1) == r_used_cnt) ?
                                   S_APPEND : S_READ;
                    end
                end
                S_APPEND: begin
                    r_used[r_target] <= r_used_cnt + ptrc_pkg::IDX_W'(1);
                    r_res_count      <= ptrc_pkg::COUNT_W'(1);
                    r_res_slot       <= ptrc_pkg::SLOT_W'(r_idx);
                    r_res_restart    <= r_wb || r_dirty[r_target];
                    if (r_wb) begin
                        r_dirty[r_target] <= 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        o_out_valid    <= 1'b1;
                        o_status       <= r_res_status;
                        o_count_after  <= r_res_count;
                        o_slot         <= r_res_slot;
                        o_restart_save <= r_res_restart;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_rejected_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ptrc_pkg::STATUS_FULL) |->
        (o_count_after == '0 && o_slot == '0 && !o_restart_save))
        else $error("rejected update carries nonzero fields");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> (r_idx < ptrc_pkg::IDX_W'(ptrc_pkg::ENTRIES_PER_TARGET) && w_tgt_ok))
        else $error("entry write outside the target table");

    a_append_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPEND) |-> (r_idx == r_used_cnt))
        else $error("append not at the end of the used entries");

    a_used_grows_by_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPEND) |=> (r_used[r_target] == $past(r_used_cnt) + ptrc_pkg::IDX_W'(1)))
        else $error("used count not advanced after append");

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !w_out_free) |=> (r_state == S_DONE && o_out_valid))
        else $error("result left the sequencer while the output register was held");
`endif

endmodule
